// ----- rtl/pav_pkg.sv -----
// pav_pkg: shared types, character codes and helper functions for the
// property attribute validator. No dependencies.
`default_nettype none

package pav_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int LVL_W = $clog2(STACK_DEPTH + 1);
    localparam int PTR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // bracket stack level, 0 to STACK_DEPTH
    typedef logic [LVL_W-1:0] lvl_t;

    // character codes
    localparam logic [7:0] CH_LCURLY = 8'h7B;
    localparam logic [7:0] CH_LSQ    = 8'h5B;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RCURLY = 8'h7D;
    localparam logic [7:0] CH_RSQ    = 8'h5D;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DOLLAR = 8'h24;

    // field keys
    localparam logic [7:0] KEY_T     = 8'h54;
    localparam logic [7:0] KEY_G     = 8'h47;
    localparam logic [7:0] KEY_V     = 8'h56;
    localparam logic [7:0] KEY_S     = 8'h53;
    localparam logic [7:0] KEY_C     = 8'h43;
    localparam logic [7:0] KEY_AMP   = 8'h26;
    localparam logic [7:0] KEY_W     = 8'h57;
    localparam logic [7:0] KEY_R     = 8'h52;
    localparam logic [7:0] KEY_QMARK = 8'h3F;
    localparam logic [7:0] KEY_N     = 8'h4E;
    localparam logic [7:0] KEY_D     = 8'h44;
    localparam logic [7:0] KEY_P     = 8'h50;

    typedef enum logic [1:0] {
        BRK_CURLY  = 2'd0,
        BRK_SQUARE = 2'd1,
        BRK_ROUND  = 2'd2
    } brk_t;

    // state of the field being scanned
    typedef struct packed {
        logic [7:0] key;
        logic       nonempty;
        logic       ident_ok;
        logic       prefix_ok;
        logic       colon;
    } field_t;

    // verdict on a closed field
    typedef struct packed {
        logic ok;
        logic owner;
    } check_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic ident_start(input logic [7:0] c);
        return is_letter(c) || c == CH_UNDER || c == CH_DOLLAR;
    endfunction

    function automatic logic ident_body(input logic [7:0] c);
        return ident_start(c) || (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic is_opener(input logic [7:0] c);
        return c == CH_LCURLY || c == CH_LSQ || c == CH_LPAR;
    endfunction

    function automatic logic is_closer(input logic [7:0] c);
        return c == CH_RCURLY || c == CH_RSQ || c == CH_RPAR;
    endfunction

    function automatic brk_t brk_code(input logic [7:0] c);
        brk_t code;
        if (c == CH_LCURLY || c == CH_RCURLY)
        begin
            code = BRK_CURLY;
        end
        else if (c == CH_LSQ || c == CH_RSQ)
        begin
            code = BRK_SQUARE;
        end
        else
        begin
            code = BRK_ROUND;
        end
        return code;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/pav_field_check.sv -----
// pav_field_check: rule check of one closed field against its key.
// Depends on pav_pkg.
`default_nettype none

module pav_field_check (
    input  var pav_pkg::field_t fld,
    output var pav_pkg::check_t result
);

    always_comb begin
        result = '0;
        case (fld.key)
            pav_pkg::KEY_T:
            begin
                result.ok = fld.nonempty;
            end
            pav_pkg::KEY_G, pav_pkg::KEY_V:
            begin
                result.ok = fld.ident_ok;
            end
            pav_pkg::KEY_S:
            begin
                result.ok = fld.colon && fld.prefix_ok;
            end
            pav_pkg::KEY_C, pav_pkg::KEY_AMP, pav_pkg::KEY_W:
            begin
                result.ok    = !fld.nonempty;
                result.owner = 1'b1;
            end
            pav_pkg::KEY_R, pav_pkg::KEY_QMARK, pav_pkg::KEY_N, pav_pkg::KEY_D,
            pav_pkg::KEY_P:
            begin
                result.ok = !fld.nonempty;
            end
            default:
            begin
                result.ok = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/property_attribute_validator_unit.sv -----
// property_attribute_validator_unit: top level, byte scanner and verdict register.
// Depends on pav_pkg and pav_field_check.
`default_nettype none

// Scans a property attribute string at one byte per clock and gives one verdict
// beat on the string's last byte (or on an is_empty beat). An accepted byte is held
// in an input register, then folded into the scan state (quote flag, bracket stack
// of pav_pkg::STACK_DEPTH entries, key table, field flags) and, at the end of a
// string, the verdict is loaded into the output register, which then offers
// the verdict beat; a new byte is taken every cycle, and only a verdict held by
// a stalled output side holds up the input. All scan state but the bracket stack
// entries returns to its reset value at the edge that loads the verdict, so
// strings follow each other with no gap.
module property_attribute_validator_unit (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_ready,
    input  wire  [7:0] ch,
    input  wire        last,
    input  wire        is_empty,
    output logic       out_valid,
    input  wire        out_ready,
    output logic       well_formed,
    output logic       rules_ok,
    output logic       read_only,
    output logic       optional_flag,
    output logic       custom_getter,
    output logic       custom_setter,
    output logic       setter_exists,
    output logic [1:0] ownership_count
);

    // input register
    logic       in_valid_reg;
    logic [7:0] ch_reg;
    logic       last_reg;
    logic       empty_reg;

    // scan state
    logic             quote_reg;
    pav_pkg::lvl_t    lvl_reg;
    logic             at_key_reg;
    pav_pkg::field_t  fld_reg;
    logic             mal_reg;
    logic             rb_reg;
    logic [1:0]       owner_reg;
    logic [255:0]     seen_reg;
    pav_pkg::brk_t    stack_reg [pav_pkg::STACK_DEPTH];

    // output register
    logic       out_valid_reg;
    logic       wf_reg;
    logic       rok_reg;
    logic       ro_reg;
    logic       opt_reg;
    logic       get_reg;
    logic       set_reg;
    logic       sex_reg;
    logic [1:0] own_reg;

    // step logic
    logic             is_end;
    logic             advance;
    pav_pkg::lvl_t    lvl_dec;
    pav_pkg::brk_t    stack_rd;
    logic             quote_next;
    pav_pkg::lvl_t    lvl_next;
    logic             at_key_next;
    pav_pkg::field_t  fld_next;
    logic             mal_byte;
    logic             mal_next;
    logic             rb_next;
    logic [1:0]       owner_next;
    logic [255:0]     seen_next;
    logic             push;
    pav_pkg::brk_t    push_code;
    logic             close_a;
    logic             close_b;
    logic             do_close;
    logic             dup;
    logic             commit;
    logic             done;
    pav_pkg::check_t  chk;
    logic             wf_next;
    logic             r_next;
    logic             s_next;

    assign is_end   = last_reg || empty_reg;
    assign advance  = in_valid_reg && (!is_end || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign lvl_dec  = lvl_reg - pav_pkg::lvl_t'(1);
    assign stack_rd = stack_reg[lvl_dec[pav_pkg::PTR_W-1:0]];

    // one byte of the string
    always_comb
    begin
        quote_next  = quote_reg;
        lvl_next    = lvl_reg;
        at_key_next = at_key_reg;
        fld_next    = fld_reg;
        mal_byte    = mal_reg;
        push        = 1'b0;
        push_code   = pav_pkg::BRK_CURLY;
        close_a     = 1'b0;
        done        = 1'b0;
        if (!empty_reg && !mal_reg)
        begin
            if (ch_reg == pav_pkg::CH_BSLASH)
            begin
                mal_byte = 1'b1;
            end
            else
            begin
                if (ch_reg == pav_pkg::CH_QUOTE)
                begin
                    quote_next = !quote_reg;
                end
                if (!quote_next)
                begin
                    if (pav_pkg::is_opener(ch_reg))
                    begin
                        if (lvl_reg == pav_pkg::lvl_t'(pav_pkg::STACK_DEPTH))
                        begin
                            mal_byte = 1'b1;
                            done     = 1'b1;
                        end
                        else
                        begin
                            push      = 1'b1;
                            push_code = pav_pkg::brk_code(ch_reg);
                            lvl_next  = lvl_reg + pav_pkg::lvl_t'(1);
                        end
                    end
                    else if (pav_pkg::is_closer(ch_reg))
                    begin
                        if (lvl_reg == '0 || stack_rd != pav_pkg::brk_code(ch_reg))
                        begin
                            mal_byte = 1'b1;
                            done     = 1'b1;
                        end
                        else
                        begin
                            lvl_next = lvl_dec;
                        end
                    end
                    if (!done && ch_reg == pav_pkg::CH_COMMA && lvl_next == '0)
                    begin
                        close_a = 1'b1;
                        done    = 1'b1;
                    end
                end
                if (!done)
                begin
                    if (at_key_reg)
                    begin
                        at_key_next = 1'b0;
                        fld_next    = '0;
                        fld_next.key = ch_reg;
                    end
                    else
                    begin
                        fld_next.prefix_ok = fld_reg.ident_ok;
                        fld_next.ident_ok  = fld_reg.nonempty
                                           ? (fld_reg.ident_ok && pav_pkg::ident_body(ch_reg))
                                           : pav_pkg::ident_start(ch_reg);
                        fld_next.nonempty  = 1'b1;
                        fld_next.colon     = (ch_reg == pav_pkg::CH_COLON);
                    end
                end
            end
        end
    end

    pav_field_check u_check (
        .fld    (fld_next),
        .result (chk)
    );

    // field close: a top-level comma, or the end of the string
    always_comb
    begin
        close_b  = is_end && !mal_byte && !quote_next && lvl_next == '0 && !close_a;
        do_close = close_a || close_b;
        dup      = at_key_next || seen_reg[fld_next.key];
        commit   = do_close && !dup;
        mal_next = mal_byte;
        if (is_end && !mal_byte && (quote_next || lvl_next != '0 || close_a))
        begin
            mal_next = 1'b1;
        end
        if (do_close && dup)
        begin
            mal_next = 1'b1;
        end
        seen_next  = seen_reg;
        owner_next = owner_reg;
        rb_next    = rb_reg;
        if (commit)
        begin
            seen_next[fld_next.key] = 1'b1;
            if (chk.owner && owner_reg != 2'd3)
            begin
                owner_next = owner_reg + 2'd1;
            end
            if (!chk.ok)
            begin
                rb_next = 1'b1;
            end
        end
        wf_next = !mal_next;
        r_next  = wf_next && seen_next[pav_pkg::KEY_R];
        s_next  = wf_next && seen_next[pav_pkg::KEY_S];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            ch_reg    <= ch;
            last_reg  <= last;
            empty_reg <= is_empty;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_reg  <= 1'b0;
            lvl_reg    <= '0;
            at_key_reg <= 1'b1;
            fld_reg    <= '0;
            mal_reg    <= 1'b0;
            rb_reg     <= 1'b0;
            owner_reg  <= 2'd0;
            seen_reg   <= '0;
        end
        else if (advance)
        begin
            if (is_end)
            begin
                quote_reg  <= 1'b0;
                lvl_reg    <= '0;
                at_key_reg <= 1'b1;
                fld_reg    <= '0;
                mal_reg    <= 1'b0;
                rb_reg     <= 1'b0;
                owner_reg  <= 2'd0;
                seen_reg   <= '0;
            end
            else
            begin
                quote_reg  <= quote_next;
                lvl_reg    <= lvl_next;
                at_key_reg <= do_close ? 1'b1 : at_key_next;
                fld_reg    <= do_close ? '0 : fld_next;
                mal_reg    <= mal_next;
                rb_reg     <= rb_next;
                owner_reg  <= owner_next;
                seen_reg   <= seen_next;
            end
        end
    end

    // bracket stack entries are only read below the level, so no reset
    always_ff @(posedge clk)
    begin
        if (advance && push)
        begin
            stack_reg[lvl_reg[pav_pkg::PTR_W-1:0]] <= push_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && is_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_end)
        begin
            wf_reg  <= wf_next;
            rok_reg <= wf_next && !rb_next && seen_next[pav_pkg::KEY_T]
                       && owner_next <= 2'd1 && !(r_next && s_next);
            ro_reg  <= r_next;
            opt_reg <= wf_next && seen_next[pav_pkg::KEY_QMARK];
            get_reg <= wf_next && seen_next[pav_pkg::KEY_G];
            set_reg <= s_next;
            sex_reg <= !(r_next && !s_next);
            own_reg <= wf_next ? owner_next : 2'd0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign well_formed     = wf_reg;
    assign rules_ok        = rok_reg;
    assign read_only       = ro_reg;
    assign optional_flag   = opt_reg;
    assign custom_getter   = get_reg;
    assign custom_setter   = set_reg;
    assign setter_exists   = sex_reg;
    assign ownership_count = own_reg;

`ifndef SYNTHESIS
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lvl_reg <= pav_pkg::lvl_t'(pav_pkg::STACK_DEPTH))
        else $error("bracket level beyond stack depth");

    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_end |=> seen_reg == '0 && owner_reg == 2'd0 && lvl_reg == '0
                             && !mal_reg && at_key_reg)
        else $error("scan state not cleared after end of string");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(ch_reg) && $stable(last_reg))
        else $error("held beat lost from input register");

    a_malformed_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !wf_reg |-> !rok_reg && !ro_reg && !set_reg && own_reg == 2'd0)
        else $error("flags set on malformed verdict");

    a_setter: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !sex_reg |-> ro_reg && !set_reg)
        else $error("setter_exists inconsistent with read_only");
`endif

endmodule

`default_nettype wire
